/* src/djb2_bitmap_distinct_counter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the djb2 bitmap distinct counter
// Thin wrappers round concurrent assertions clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DJB2_BITMAP_DISTINCT_COUNTER_ASSERT_SVH
`define DJB2_BITMAP_DISTINCT_COUNTER_ASSERT_SVH

// same-cycle implication
`define DBDC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dbdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdc_pkg
// Shared constants and types for the djb2 bitmap distinct counter.
// ----------------------------------------------------------------------------
package dbdc_pkg;

	localparam int unsigned INDEX_BITS_DEF = 20;
	localparam int unsigned DATA_BYTE_W    = 8;
	localparam int unsigned HASH_INDEX_W   = 20;
	localparam int unsigned COUNT_W        = 32;
	localparam int unsigned BMP_WORD_W     = 32;
	localparam int unsigned BIT_SEL_W      = 5;   // log2 of the bitmap word width
	localparam int unsigned HASH_SHIFT     = 5;   // x33 = (x << 5) + x
	localparam logic [31:0] HASH_SEED      = 32'd5381;

	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 88;   // 84 bits of fields, padded to bytes
	localparam int unsigned M_TUSER_W = 1;

	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [BMP_WORD_W-1:0] bmp_word_t;

endpackage

/* src/dbdc_bitmap_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdc_bitmap_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dbdc_bitmap_ram
	import dbdc_pkg::*;
#(
	parameter int unsigned ADDR_W = INDEX_BITS_DEF - BIT_SEL_W,
	parameter int unsigned DATA_W = BMP_WORD_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first: a read and a write to the same address return the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/djb2_bitmap_distinct_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djb2_bitmap_distinct_counter
// Per-line djb2 hash over a byte stream with a seen-bitmap distinct count.
// ----------------------------------------------------------------------------
// Usage
//  - Input stream s_*: one byte per word in s_tdata[7:0], s_tlast on the last
//    byte of each line (newline included). Bytes are hashed as signed chars;
//    a zero byte freezes the hash for the rest of its line.
//  - Output stream m_*: one word per line. m_tdata holds hash_index,
//    distinct_count and line_count; m_tuser holds first_seen.
//  - Throughput: one byte per cycle while s_tready is high, lines of one
//    byte included. The bitmap read-modify-write runs once per line on the
//    RAM's read and write ports.
//  - Pipeline: the edge taking a line's last byte reads its bitmap word into
//    the RAM stage; the output register then holds the result on m_tvalid.
//  - Reset: arst_n clears hash, counters and pipeline, then a clearing pass
//    zeroes all 2**(INDEX_BITS-5) bitmap words (32768 at the default), one
//    RAM word per cycle. s_tready stays low until it has finished.
//  - Stall: with m_tready low a result waits in the output register while
//    the next line keeps streaming in; only when a second finished line is
//    held in the RAM stage does s_tready drop.
//  - Counters saturate at 2**32-1.
// ----------------------------------------------------------------------------
module djb2_bitmap_distinct_counter
	import dbdc_pkg::*;
#(
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic                 s_tlast,   // end_of_line

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [19:0] hash_index, [51:20] distinct_count,
	                                        // [83:52] line_count, [87:84] zero
	output logic [M_TUSER_W-1:0] m_tuser    // [0] first_seen
);

`include "djb2_bitmap_distinct_counter_assert.svh"

	localparam int unsigned WADDR_W = INDEX_BITS - BIT_SEL_W;
	localparam int unsigned EXT_W   = INDEX_BITS + DATA_BYTE_W;
	localparam logic [INDEX_BITS-1:0] SEED = HASH_SEED[INDEX_BITS-1:0];
	localparam logic [WADDR_W-1:0] LAST_WADDR = '1;
	localparam count_t COUNT_MAX = '1;
	localparam int unsigned PAD_W = M_TDATA_W - HASH_INDEX_W - 2 * COUNT_W;

	// bitmap clearing pass after reset
	logic               clearing_q;
	logic [WADDR_W-1:0] clr_addr_q;

	// byte stage: running hash
	logic [INDEX_BITS-1:0] acc_q;
	logic                  stopped_q;
	logic [DATA_BYTE_W-1:0] data_byte;
	logic [EXT_W-1:0]      acc_ext;
	logic [EXT_W-1:0]      addend;
	logic [EXT_W-1:0]      hash_sum;
	logic [INDEX_BITS-1:0] hash_val;
	logic                  byte_zero;
	logic                  s_accept;
	logic                  line_end;

	// RAM stage
	logic                  s1_valid_q;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  hit_s1;
	bmp_word_t             fwd_data_s1;
	logic                  s1_fire;
	bmp_word_t             ram_rdata;
	bmp_word_t             cur_word;
	bmp_word_t             bit_mask;
	bmp_word_t             new_word;
	logic                  fresh;
	logic [WADDR_W-1:0]    word_s1;
	logic [WADDR_W-1:0]    word_in;

	// counters
	count_t dist_q;
	count_t lines_q;
	count_t dist_nxt;
	count_t lines_nxt;

	// output register
	logic                    out_valid_q;
	logic [HASH_INDEX_W-1:0] out_idx_q;
	logic                    out_first_q;
	count_t                  out_dist_q;
	count_t                  out_lines_q;

	// RAM ports
	logic               ram_we;
	logic [WADDR_W-1:0] ram_waddr;
	bmp_word_t          ram_wdata;

	// ---- handshake -------------------------------------------------------
	assign s1_fire  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !clearing_q && (!s1_valid_q || s1_fire);
	assign s_accept = s_tvalid && s_tready;
	assign line_end = s_accept && s_tlast;

	// ---- hash: acc*33 + signed byte, kept to INDEX_BITS ------------------
	assign data_byte = s_tdata[DATA_BYTE_W-1:0];
	assign byte_zero = (data_byte == '0);
	assign acc_ext   = {{DATA_BYTE_W{1'b0}}, acc_q};
	assign addend    = {{INDEX_BITS{data_byte[DATA_BYTE_W-1]}}, data_byte};
	assign hash_sum  = (acc_ext << HASH_SHIFT) + acc_ext + addend;

	always_comb begin
		if (stopped_q || byte_zero) begin
			hash_val = acc_q;
		end else begin
			hash_val = hash_sum[INDEX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= SEED;
			stopped_q <= 1'b0;
		end else if (s_accept) begin
			if (s_tlast) begin
				acc_q     <= SEED;
				stopped_q <= 1'b0;
			end else begin
				acc_q     <= hash_val;
				stopped_q <= stopped_q || byte_zero;
			end
		end
	end

	// ---- clearing pass ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + WADDR_W'(1);
			if (clr_addr_q == LAST_WADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---- RAM stage --------------------------------------------------------
	assign word_in = hash_val[INDEX_BITS-1:BIT_SEL_W];
	assign word_s1 = idx_s1[INDEX_BITS-1:BIT_SEL_W];

	// a write landing on the edge of the read is not seen by the RAM: forward it
	assign cur_word = hit_s1 ? fwd_data_s1 : ram_rdata;
	assign bit_mask = bmp_word_t'(1) << idx_s1[BIT_SEL_W-1:0];
	assign fresh    = (cur_word & bit_mask) == '0;
	assign new_word = cur_word | bit_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			hit_s1     <= 1'b0;
		end else if (line_end) begin
			s1_valid_q <= 1'b1;
			hit_s1     <= s1_fire && (word_s1 == word_in);
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
			hit_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_end) begin
			idx_s1      <= hash_val;
			fwd_data_s1 <= new_word;
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_fire;
			ram_waddr = word_s1;
			ram_wdata = new_word;
		end
	end

	dbdc_bitmap_ram #(
		.ADDR_W(WADDR_W),
		.DATA_W(BMP_WORD_W)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (line_end),
		.raddr(word_in),
		.rdata(ram_rdata)
	);

	// ---- saturating counters ----------------------------------------------
	assign dist_nxt  = (fresh && dist_q != COUNT_MAX) ? dist_q + count_t'(1) : dist_q;
	assign lines_nxt = (lines_q != COUNT_MAX) ? lines_q + count_t'(1) : lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= '0;
			lines_q <= '0;
		end else if (s1_fire) begin
			dist_q  <= dist_nxt;
			lines_q <= lines_nxt;
		end
	end

	// ---- output register --------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_idx_q   <= HASH_INDEX_W'(idx_s1);
			out_first_q <= fresh;
			out_dist_q  <= dist_nxt;
			out_lines_q <= lines_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_lines_q, out_dist_q, out_idx_q};
	assign m_tuser  = out_first_q;

	// ---- assertions -------------------------------------------------------
	`DBDC_ASSERT_SAME(a_no_accept_clearing, clearing_q, !s_tready,
		"input taken during bitmap clearing")
	`DBDC_ASSERT_SAME(a_no_line_clearing, clearing_q, !s1_valid_q,
		"line in RAM stage during bitmap clearing")
	`DBDC_ASSERT_NEXT(a_fire_loads_out, s1_fire, out_valid_q,
		"RAM stage fired but output register empty")
	`DBDC_ASSERT_SAME(a_dist_le_lines, out_valid_q, out_dist_q <= out_lines_q,
		"distinct count above line count")

endmodule
